FILE: hw/rtl/bpd_pkg.sv
// Shared types and constants for the PackBits / ByteRun1 decoder.
// Used by bpd_ctrl, bpd_datapath and byterun_packbits_decoder_unit.
package bpd_pkg;

  // Repeat runs go out in results of at most this many bytes.
  localparam int BYTES_PER_RESULT = 8;
  localparam int CHUNK_BYTES = (BYTES_PER_RESULT > 8) ? 8 :
                               ((BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT);

  localparam int          OUT_BYTES_W  = 64;
  localparam int          COUNT_W      = 4;
  localparam int          JOB_W        = 32;
  localparam logic [JOB_W-1:0] EXPECTED_LENGTH_RESET = 32'd1;
  localparam logic [8:0]  REPEAT_BASE  = 9'h101;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_LITERAL = 2'd1,
    ST_REP_VAL = 2'd2,
    ST_REP_OUT = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr_take;   // header byte transferred
    logic lit_take;   // literal byte transferred
    logic val_take;   // repeat value byte transferred
    logic emit_chunk; // push one packed repeat result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;   // output register holds a result
    logic overrun;     // current header byte would exceed the job
    logic hdr_repeat;  // current header byte starts a repeat run
    logic lit_last;    // one literal byte left in the run
    logic chunk_last;  // the next repeat result ends the run
  } dp_status_t;

endpackage

FILE: hw/rtl/bpd_ctrl.sv
// Controller state machine of the PackBits decoder.
// Depends on bpd_pkg for the state type and the command/status structs.
module bpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  bpd_pkg::dp_status_t status,
  output bpd_pkg::dp_cmd_t    cmd
);

  bpd_pkg::state_t state;
  bpd_pkg::state_t state_next;
  logic            out_free;
  logic            in_take;

  // The output register can take a new result this cycle.
  assign out_free = !status.out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpd_pkg::ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpd_pkg::ST_HEADER: begin
        if (in_take && !status.overrun) begin
          state_next = status.hdr_repeat ? bpd_pkg::ST_REP_VAL : bpd_pkg::ST_LITERAL;
        end
      end
      bpd_pkg::ST_LITERAL: begin
        if (in_take && status.lit_last) begin
          state_next = bpd_pkg::ST_HEADER;
        end
      end
      bpd_pkg::ST_REP_VAL: begin
        if (in_take) begin
          state_next = bpd_pkg::ST_REP_OUT;
        end
      end
      bpd_pkg::ST_REP_OUT: begin
        if (out_free && status.chunk_last) begin
          state_next = bpd_pkg::ST_HEADER;
        end
      end
      default: state_next = bpd_pkg::ST_HEADER;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.hdr_take   = 1'b0;
    cmd.lit_take   = 1'b0;
    cmd.val_take   = 1'b0;
    cmd.emit_chunk = 1'b0;
    unique case (state)
      bpd_pkg::ST_HEADER: begin
        in_ready     = out_free;
        cmd.hdr_take = in_take;
      end
      bpd_pkg::ST_LITERAL: begin
        in_ready     = out_free;
        cmd.lit_take = in_take;
      end
      bpd_pkg::ST_REP_VAL: begin
        in_ready     = 1'b1;
        cmd.val_take = in_take;
      end
      bpd_pkg::ST_REP_OUT: begin
        cmd.emit_chunk = out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/bpd_datapath.sv
// Datapath of the PackBits decoder: length counters, repeat value and the
// output register. Depends on bpd_pkg for constants and command/status structs.
module bpd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpd_pkg::JOB_W-1:0]     cfg_wdata,
  input  logic [7:0]                    in_byte,
  input  logic                          out_ready,
  input  bpd_pkg::dp_cmd_t              cmd,
  output bpd_pkg::dp_status_t           status,
  output logic                          out_valid,
  output logic [bpd_pkg::OUT_BYTES_W-1:0] out_bytes,
  output logic [bpd_pkg::COUNT_W-1:0]   byte_count,
  output logic                          last_of_item,
  output logic                          job_done,
  output logic                          overrun_error
);

  logic [bpd_pkg::JOB_W-1:0] expected_length;
  logic [bpd_pkg::JOB_W-1:0] job_left;
  logic [7:0]                run_left;
  logic [7:0]                rep_value;

  logic [8:0]                run_len;
  logic                      job_zero;
  logic [bpd_pkg::COUNT_W-1:0] chunk_n;
  logic [bpd_pkg::OUT_BYTES_W-1:0] chunk_bytes;

  // Run length of a header: 0x101 - h for a repeat, h + 1 for a literal.
  always_comb begin
    if (in_byte[7]) begin
      run_len = bpd_pkg::REPEAT_BASE - {1'b0, in_byte};
    end else begin
      run_len = {1'b0, in_byte} + 9'd1;
    end
  end

  assign job_zero = (job_left == '0);

  always_comb begin
    if (run_left > 8'(bpd_pkg::CHUNK_BYTES)) begin
      chunk_n = bpd_pkg::COUNT_W'(bpd_pkg::CHUNK_BYTES);
    end else begin
      chunk_n = run_left[bpd_pkg::COUNT_W-1:0];
    end
  end

  // Bytes above the count stay zero.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chunk_bytes[8*i +: 8] = (4'(i) < chunk_n) ? rep_value : 8'h00;
    end
  end

  assign status.out_valid  = out_valid;
  assign status.overrun    = {{(bpd_pkg::JOB_W-9){1'b0}}, run_len} > job_left;
  assign status.hdr_repeat = in_byte[7];
  assign status.lit_last   = (run_left == 8'd1);
  assign status.chunk_last = (run_left <= 8'(bpd_pkg::CHUNK_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= bpd_pkg::EXPECTED_LENGTH_RESET;
    end else if (cfg_we) begin
      expected_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_left <= bpd_pkg::EXPECTED_LENGTH_RESET;
      run_left <= '0;
    end else begin
      if (cmd.hdr_take) begin
        if (status.overrun) begin
          job_left <= expected_length;
          run_left <= '0;
        end else begin
          job_left <= job_left - {{(bpd_pkg::JOB_W-9){1'b0}}, run_len};
          run_left <= run_len[7:0];
        end
      end else if (cmd.lit_take) begin
        run_left <= run_left - 8'd1;
        if (status.lit_last && job_zero) begin
          job_left <= expected_length;
        end
      end else if (cmd.emit_chunk) begin
        run_left <= run_left - {4'd0, chunk_n};
        if (status.chunk_last && job_zero) begin
          job_left <= expected_length;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_take) begin
      rep_value <= in_byte;
    end
  end

  // Output register: loaded by a literal byte, a repeat chunk or an overrun.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.hdr_take && status.overrun) || cmd.lit_take || cmd.emit_chunk) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_take && status.overrun) begin
      out_bytes     <= '0;
      byte_count    <= '0;
      last_of_item  <= 1'b1;
      job_done      <= 1'b0;
      overrun_error <= 1'b1;
    end else if (cmd.lit_take) begin
      out_bytes     <= {{(bpd_pkg::OUT_BYTES_W-8){1'b0}}, in_byte};
      byte_count    <= bpd_pkg::COUNT_W'(1);
      last_of_item  <= 1'b1;
      job_done      <= status.lit_last && job_zero;
      overrun_error <= 1'b0;
    end else if (cmd.emit_chunk) begin
      out_bytes     <= chunk_bytes;
      byte_count    <= chunk_n;
      last_of_item  <= status.chunk_last;
      job_done      <= status.chunk_last && job_zero;
      overrun_error <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/byterun_packbits_decoder_unit.sv
// Top level of the PackBits / ByteRun1 decoder.
// Instantiates bpd_ctrl and bpd_datapath; uses bpd_pkg.
//
//  Channel  Handshake            Payload
//  -------  -------------------  -------------------------------------------
//  input    in_valid / in_ready  in_byte
//  output   out_valid/out_ready  out_bytes, byte_count, last_of_item,
//                                job_done, overrun_error
//  config   cfg_we (no wait)     cfg_wdata (expected_length)
//
// A literal byte gives one result. A repeat run takes the value byte, then
// emits its bytes as packed results of up to 8 bytes each through the
// single output register. rst is synchronous; after reset the expected
// length is 1. A stalled output holds the result and blocks input transfers
// that would produce another result.
module byterun_packbits_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last_of_item,
  output logic        job_done,
  output logic        overrun_error
);

  bpd_pkg::dp_cmd_t    cmd;
  bpd_pkg::dp_status_t status;

  bpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_byte),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_bytes     (out_bytes),
    .byte_count    (byte_count),
    .last_of_item  (last_of_item),
    .job_done      (job_done),
    .overrun_error (overrun_error)
  );

endmodule
